// ----- hw/rtl/msc_pkg.sv -----
// Package for the magnetometer sample calibration block: widths, register
// indexes, gain constants, the gain-code decoder and the output clamp.
// Used by every file under hw/rtl; depends on nothing.
package msc_pkg;

	localparam int CNT_W         = 16;
	localparam int OUT_W         = 19;
	localparam int OTP_W         = 8;
	localparam int CFG_IDX_W     = 1;
	localparam int OUT_FRAC_BITS = 12;

	localparam logic [CFG_IDX_W-1:0] REG_OTP_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OTP_HIGH = 1'b1;

	localparam int CODE_W    = 6;
	localparam int AXIS_W    = CNT_W + 1;
	localparam int GAIN_W    = 17;
	localparam int GAIN_FRAC = 16;
	localparam int STEP_W    = 11;
	localparam int OFS_W     = 16;

	localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'd65536;
	localparam logic [GAIN_W-1:0] Z_FACTOR  = 17'd88474;
	localparam logic [STEP_W-1:0] GAIN_STEP = 11'd393;

	// product of a signed axis and a gain taken as a positive signed value
	localparam int PROD_W = AXIS_W + GAIN_W + 1;
	localparam int SHIFT  = 26 - OUT_FRAC_BITS;
	localparam int SHR_W  = PROD_W - SHIFT;
	localparam int SAT_W  = (SHR_W > OUT_W) ? SHR_W : OUT_W;
	localparam int OUT_MAX = 2 ** (OUT_W - 1) - 1;
	localparam int OUT_MIN = -(2 ** (OUT_W - 1));

	typedef struct packed {
		logic [GAIN_W-1:0] gain_y;
		logic [GAIN_W-1:0] gain_z;
	} gains_t;

	// codes of 32 and up stand for 32 - c, i.e. minus the low five bits
	function automatic logic signed [CODE_W-1:0] decode_code(input logic [CODE_W-1:0] c);
		logic [CODE_W-1:0] mag;
		mag = {1'b0, c[CODE_W-2:0]};
		return c[CODE_W-1] ? $signed(-mag) : $signed(mag);
	endfunction

	function automatic logic [OUT_W-1:0] clamp_out(input logic signed [SHR_W-1:0] v);
		logic signed [SAT_W-1:0] w;
		w = SAT_W'(v);
		if (w > $signed(SAT_W'(OUT_MAX)))
			return OUT_W'(OUT_MAX);
		else if (w < $signed(SAT_W'(OUT_MIN)))
			return OUT_W'(OUT_MIN);
		else
			return w[OUT_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/msc_gain.sv -----
// Calibration register file and gain builder: holds the two OTP bytes and
// turns them into registered Q16 gains for the Y and Z axes.
// Depends on msc_pkg.
module msc_gain (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [msc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [msc_pkg::OTP_W-1:0]      cfg_data,
	output msc_pkg::gains_t                gains
);

	logic [msc_pkg::OTP_W-1:0]          otp_low_q;
	logic [msc_pkg::OTP_W-1:0]          otp_high_q;
	logic signed [msc_pkg::CODE_W-1:0]  code_y;
	logic signed [msc_pkg::CODE_W-1:0]  code_z;
	logic signed [msc_pkg::OFS_W-1:0]   ofs_y;
	logic signed [msc_pkg::OFS_W-1:0]   ofs_z;
	logic signed [msc_pkg::GAIN_W:0]    sum_y;
	logic signed [msc_pkg::GAIN_W:0]    sum_z;
	logic [2*msc_pkg::GAIN_W-1:0]       zprod;
	logic [msc_pkg::GAIN_W-1:0]         gain_y_q;
	logic [msc_pkg::GAIN_W-1:0]         gbase_z_q;
	logic [msc_pkg::GAIN_W-1:0]         gain_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			otp_low_q  <= '0;
			otp_high_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				msc_pkg::REG_OTP_LOW:  otp_low_q  <= cfg_data;
				msc_pkg::REG_OTP_HIGH: otp_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		code_y = msc_pkg::decode_code(otp_low_q[5:0]);
		code_z = msc_pkg::decode_code({otp_high_q[3:0], otp_low_q[7:6]});
		ofs_y  = code_y * $signed(msc_pkg::GAIN_STEP);
		ofs_z  = code_z * $signed(msc_pkg::GAIN_STEP);
		sum_y  = $signed({1'b0, msc_pkg::GAIN_ONE}) + (msc_pkg::GAIN_W + 1)'(ofs_y);
		sum_z  = $signed({1'b0, msc_pkg::GAIN_ONE}) + (msc_pkg::GAIN_W + 1)'(ofs_z);
		zprod  = (2 * msc_pkg::GAIN_W)'(gbase_z_q) * (2 * msc_pkg::GAIN_W)'(msc_pkg::Z_FACTOR);
	end

	// gains are registered from the OTP bytes; the Z gain passes gbase_z_q, then gain_z_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_y_q  <= msc_pkg::GAIN_ONE;
			gbase_z_q <= msc_pkg::GAIN_ONE;
			gain_z_q  <= msc_pkg::Z_FACTOR;
		end else begin
			gain_y_q  <= sum_y[msc_pkg::GAIN_W-1:0];
			gbase_z_q <= sum_z[msc_pkg::GAIN_W-1:0];
			gain_z_q  <= zprod[msc_pkg::GAIN_W+msc_pkg::GAIN_FRAC-1:msc_pkg::GAIN_FRAC];
		end
	end

	assign gains.gain_y = gain_y_q;
	assign gains.gain_z = gain_z_q;

endmodule

// ----- hw/rtl/magnetometer_sample_calibrate_unit.sv -----
// Top level of the magnetometer sample calibration block.
// Depends on msc_pkg and msc_gain.

// Takes one request of three raw counts per cycle, unless the output stalls,
// and returns the calibrated X/Y/Z field in 1/4096 gauss through four register
// stages: input register, axis mixing, gain multiply, shift and clamp into the
// output register. Throughput is one request per clock while the output is not
// stalled; a stalled output holds its result and back-pressure ripples through
// the stage valids, so nothing is dropped or repeated. The two OTP bytes are
// written through the cfg port, which never stalls; new gains take effect for
// requests accepted from the next cycle on.
module magnetometer_sample_calibrate_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [msc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [msc_pkg::OTP_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [msc_pkg::CNT_W-1:0]      count_a,
	input  logic [msc_pkg::CNT_W-1:0]      count_b,
	input  logic [msc_pkg::CNT_W-1:0]      count_c,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [msc_pkg::OUT_W-1:0] field_x,
	output logic signed [msc_pkg::OUT_W-1:0] field_y,
	output logic signed [msc_pkg::OUT_W-1:0] field_z
);

	msc_pkg::gains_t gains;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic [msc_pkg::CNT_W-1:0]          a_s1, b_s1, c_s1;
	logic [msc_pkg::CNT_W-1:0]          diff, sum;
	logic signed [msc_pkg::AXIS_W-1:0]  ax, ay, az;
	logic signed [msc_pkg::AXIS_W-1:0]  ax_s2, ay_s2, az_s2;
	logic signed [msc_pkg::PROD_W-1:0]  px_s3, py_s3, pz_s3;
	logic [msc_pkg::OUT_W-1:0]          fx_s4, fy_s4, fz_s4;

	msc_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.gains     (gains)
	);

	assign cfg_ready = 1'b1;

	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// mixing mod 2^16, then the null offset is a flip of the top bit
	always_comb begin
		diff = b_s1 - c_s1;
		sum  = b_s1 + c_s1;
		ax   = msc_pkg::AXIS_W'($signed({~a_s1[msc_pkg::CNT_W-1], a_s1[msc_pkg::CNT_W-2:0]}));
		ay   = -msc_pkg::AXIS_W'($signed(diff));
		az   = msc_pkg::AXIS_W'($signed(sum));
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			a_s1 <= count_a;
			b_s1 <= count_b;
			c_s1 <= count_c;
		end
		if (en_s2) begin
			ax_s2 <= ax;
			ay_s2 <= ay;
			az_s2 <= az;
		end
		if (en_s3) begin
			px_s3 <= msc_pkg::PROD_W'(ax_s2) <<< msc_pkg::GAIN_FRAC;
			py_s3 <= ay_s2 * $signed({1'b0, gains.gain_y});
			pz_s3 <= az_s2 * $signed({1'b0, gains.gain_z});
		end
		if (en_s4) begin
			fx_s4 <= msc_pkg::clamp_out(px_s3[msc_pkg::PROD_W-1:msc_pkg::SHIFT]);
			fy_s4 <= msc_pkg::clamp_out(py_s3[msc_pkg::PROD_W-1:msc_pkg::SHIFT]);
			fz_s4 <= msc_pkg::clamp_out(pz_s3[msc_pkg::PROD_W-1:msc_pkg::SHIFT]);
		end
	end

	assign out_valid = v_s4;
	assign field_x   = $signed(fx_s4);
	assign field_y   = $signed(fy_s4);
	assign field_z   = $signed(fz_s4);

endmodule

// ----- hw/rtl/msc_chk.sv -----
// Port-level checker for the magnetometer sample calibration block, bound
// to the top level below. Depends on msc_pkg.
module msc_chk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_ready,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic signed [msc_pkg::OUT_W-1:0] field_x,
	input  logic signed [msc_pkg::OUT_W-1:0] field_y,
	input  logic signed [msc_pkg::OUT_W-1:0] field_z
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(field_x) && $stable(field_y)
			&& $stable(field_z))
		else $error("result changed while stalled");

	// an empty output register means the pipe can take a request
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// a draining output never blocks the input
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output drains");

	// X has unit gain: the result stays within two bits of the raw count range
	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> field_x[msc_pkg::OUT_W-1] == field_x[msc_pkg::OUT_W-2])
		else $error("X field outside unit-gain range");

endmodule

bind magnetometer_sample_calibrate_unit msc_chk u_msc_chk (.*);

// ----- bench/magnetometer_sample_calibrate_unit_test.sv -----
// Self-checking bench for magnetometer_sample_calibrate_unit: random and directed
// raw count requests under random back-pressure, each result checked against a local
// calibration predictor. Depends on msc_pkg and the RTL under hw/rtl.
`timescale 1ns / 100ps

module magnetometer_sample_calibrate_unit_test;

	localparam longint CNT_OFFSET  = 32768;
	localparam longint GAIN_UNITY  = 65536;
	localparam longint GAIN_INCR   = 393;
	localparam longint Z_SCALE     = 88474;
	localparam int     FIELD_SHIFT = 26 - msc_pkg::OUT_FRAC_BITS;
	localparam longint FIELD_MAX   = (longint'(1) << (msc_pkg::OUT_W - 1)) - 1;
	localparam longint FIELD_MIN   = -(longint'(1) << (msc_pkg::OUT_W - 1));
	localparam int     IDLE_PCT    = 18;
	localparam int     HOLD_CYCLES = 80;
	localparam int     SETTLE      = 8;

	typedef enum logic [2:0] {
		OP_SAMPLE,
		OP_CONFIG,
		OP_DRAIN,
		OP_STALL,
		OP_STEADY
	} bench_kind_t;

	typedef struct {
		bench_kind_t                     kind;
		logic [msc_pkg::CNT_W-1:0]       a;
		logic [msc_pkg::CNT_W-1:0]       b;
		logic [msc_pkg::CNT_W-1:0]       c;
		logic [msc_pkg::CFG_IDX_W-1:0]   idx;
		logic [msc_pkg::OTP_W-1:0]       data;
		bit                              flag;
	} bench_op_t;

	typedef struct {
		logic signed [msc_pkg::OUT_W-1:0] x;
		logic signed [msc_pkg::OUT_W-1:0] y;
		logic signed [msc_pkg::OUT_W-1:0] z;
	} field_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [msc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [msc_pkg::OTP_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [msc_pkg::CNT_W-1:0] count_a = '0;
	logic [msc_pkg::CNT_W-1:0] count_b = '0;
	logic [msc_pkg::CNT_W-1:0] count_c = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [msc_pkg::OUT_W-1:0] field_x;
	logic signed [msc_pkg::OUT_W-1:0] field_y;
	logic signed [msc_pkg::OUT_W-1:0] field_z;

	bench_op_t  pending_ops[$];
	field_set_t expected_fields[$];

	logic [msc_pkg::OTP_W-1:0] otp_low_shadow = '0;
	logic [msc_pkg::OTP_W-1:0] otp_high_shadow = '0;

	bit in_fire = 1'b0;
	bit cfg_fire = 1'b0;
	bit steady = 1'b0;
	int stall_asked = 0;
	int stall_served = 0;
	int hold_left = 0;
	int settle_count = 0;

	int samples_checked = 0;
	int cfg_writes = 0;
	int mismatches = 0;
	int stray_results = 0;

	magnetometer_sample_calibrate_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.count_a   (count_a),
		.count_b   (count_b),
		.count_c   (count_c),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.field_x   (field_x),
		.field_y   (field_y),
		.field_z   (field_z)
	);

	always #5 clk = ~clk;

	// 6-bit code: 32 and up means 32 - code
	function automatic longint gain_code(input logic [5:0] code);
		return (code >= 6'd32) ? 32 - longint'(code) : longint'(code);
	endfunction

	function automatic logic signed [msc_pkg::OUT_W-1:0] scale_field(input longint axis,
			input longint gain);
		longint prod;
		longint r;
		prod = axis * gain;
		r = prod >>> FIELD_SHIFT;
		if (r > FIELD_MAX)
			r = FIELD_MAX;
		if (r < FIELD_MIN)
			r = FIELD_MIN;
		return r[msc_pkg::OUT_W-1:0];
	endfunction

	function automatic field_set_t calibrate_sample(input logic [msc_pkg::CNT_W-1:0] a,
			input logic [msc_pkg::CNT_W-1:0] b, input logic [msc_pkg::CNT_W-1:0] c,
			input logic [msc_pkg::OTP_W-1:0] lo, input logic [msc_pkg::OTP_W-1:0] hi);
		logic [msc_pkg::CNT_W-1:0] mix_y;
		logic [msc_pkg::CNT_W-1:0] mix_z;
		longint gain_y;
		longint gain_z;
		longint base_z;
		field_set_t res;
		mix_y = b - c + 16'h8000;
		mix_z = b + c - 16'h8000;
		gain_y = GAIN_UNITY + gain_code(lo[5:0]) * GAIN_INCR;
		base_z = GAIN_UNITY + gain_code({hi[3:0], lo[7:6]}) * GAIN_INCR;
		gain_z = (base_z * Z_SCALE) >>> 16;
		res.x = scale_field(longint'(a) - CNT_OFFSET, GAIN_UNITY);
		res.y = scale_field(CNT_OFFSET - longint'(mix_y), gain_y);
		res.z = scale_field(longint'(mix_z) - CNT_OFFSET, gain_z);
		return res;
	endfunction

	// counts biased toward the edges and the null point now and then
	function automatic logic [msc_pkg::CNT_W-1:0] pick_count();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'(32764 + $urandom_range(8));
			3: return 16'($urandom_range(3));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_sample(input logic [msc_pkg::CNT_W-1:0] a,
			input logic [msc_pkg::CNT_W-1:0] b, input logic [msc_pkg::CNT_W-1:0] c);
		bench_op_t op;
		op = '{kind: OP_SAMPLE, a: a, b: b, c: c, idx: '0, data: '0, flag: 1'b0};
		pending_ops.push_back(op);
	endtask

	task automatic queue_marker(input bench_kind_t kind, input bit flag);
		bench_op_t op;
		op = '{kind: kind, a: '0, b: '0, c: '0, idx: '0, data: '0, flag: flag};
		pending_ops.push_back(op);
	endtask

	task automatic queue_otp(input logic [msc_pkg::OTP_W-1:0] lo,
			input logic [msc_pkg::OTP_W-1:0] hi);
		bench_op_t op_lo;
		bench_op_t op_hi;
		op_lo = '{kind: OP_CONFIG, a: '0, b: '0, c: '0, idx: msc_pkg::REG_OTP_LOW,
			data: lo, flag: 1'b0};
		op_hi = '{kind: OP_CONFIG, a: '0, b: '0, c: '0, idx: msc_pkg::REG_OTP_HIGH,
			data: hi, flag: 1'b0};
		queue_marker(OP_DRAIN, 1'b0);
		if ($urandom_range(1)) begin
			pending_ops.push_back(op_lo);
			pending_ops.push_back(op_hi);
		end else begin
			pending_ops.push_back(op_hi);
			pending_ops.push_back(op_lo);
		end
	endtask

	// request driver: walks the op queue, one request in flight per channel
	always @(negedge clk) begin : drive_requests
		bench_op_t op;
		bit in_busy;
		bit cfg_busy;
		bit next_in_valid;
		bit next_cfg_valid;
		if (arst_n) begin
			in_busy = in_valid && !in_fire;
			cfg_busy = cfg_valid && !cfg_fire;
			next_in_valid = in_busy;
			next_cfg_valid = cfg_busy;
			if (!in_busy && !cfg_busy && pending_ops.size() != 0) begin
				op = pending_ops[0];
				case (op.kind)
					OP_SAMPLE: begin
						if (steady || $urandom_range(99) >= IDLE_PCT) begin
							next_in_valid = 1'b1;
							count_a <= op.a;
							count_b <= op.b;
							count_c <= op.c;
							void'(pending_ops.pop_front());
						end
					end
					OP_CONFIG: begin
						next_cfg_valid = 1'b1;
						cfg_index <= op.idx;
						cfg_data <= op.data;
						void'(pending_ops.pop_front());
					end
					OP_DRAIN: begin
						// hold off until the pipe is empty and settle_count has reached SETTLE
						if (expected_fields.size() != 0) begin
							settle_count = 0;
						end else if (settle_count >= SETTLE) begin
							settle_count = 0;
							void'(pending_ops.pop_front());
						end else begin
							settle_count++;
						end
					end
					OP_STALL: begin
						stall_asked <= stall_asked + 1;
						void'(pending_ops.pop_front());
					end
					OP_STEADY: begin
						steady <= op.flag;
						void'(pending_ops.pop_front());
					end
					default: void'(pending_ops.pop_front());
				endcase
			end
			in_valid <= next_in_valid;
			cfg_valid <= next_cfg_valid;
		end
	end

	// result receiver with random and long hold-offs
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_asked != stall_served) begin
				stall_served++;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// monitor: check results first, then record new requests and OTP writes
	always @(posedge clk) begin : watch_ports
		field_set_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_fields.size() == 0) begin
					stray_results++;
					if (mismatches + stray_results <= 10)
						$display("%0t: unexpected result x=%0d y=%0d z=%0d", $realtime,
							field_x, field_y, field_z);
				end else begin
					want = expected_fields.pop_front();
					samples_checked++;
					if (field_x !== want.x || field_y !== want.y || field_z !== want.z) begin
						mismatches++;
						if (mismatches + stray_results <= 10)
							$display("%0t: mismatch exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
								$realtime, want.x, want.y, want.z, field_x, field_y, field_z);
					end
				end
			end
			if (in_valid && in_ready)
				expected_fields.push_back(calibrate_sample(count_a, count_b, count_c,
					otp_low_shadow, otp_high_shadow));
			if (cfg_valid && cfg_ready) begin
				cfg_writes++;
				case (cfg_index)
					msc_pkg::REG_OTP_LOW:  otp_low_shadow = cfg_data;
					msc_pkg::REG_OTP_HIGH: otp_high_shadow = cfg_data;
					default: ;
				endcase
			end
			in_fire <= in_valid && in_ready;
			cfg_fire <= cfg_valid && cfg_ready;
		end
	end

	initial begin
		#2_000_000;
		$display("FAIL magnetometer_sample_calibrate_unit");
		$finish;
	end

	initial begin : stimulus
		logic [msc_pkg::CNT_W-1:0] edge_a[6];
		logic [msc_pkg::CNT_W-1:0] edge_b[6];
		logic [msc_pkg::CNT_W-1:0] edge_c[6];
		logic [msc_pkg::OTP_W-1:0] lo;
		logic [msc_pkg::OTP_W-1:0] hi;
		int grp;
		int k;
		int phase;
		int n;

		// zero axes, full-scale, Y/Z extremes and mixing wrap
		edge_a = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001};
		edge_b = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001};
		edge_c = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF};

		// reset values first, then max positive codes, max negative codes
		// with the ignored high bits set, and the code 32 that decodes to zero
		for (grp = 0; grp < 4; grp++) begin
			case (grp)
				1: queue_otp(8'hDF, 8'h07);
				2: queue_otp(8'hFF, 8'hFF);
				3: queue_otp(8'h20, 8'h08);
				default: ;
			endcase
			for (k = 0; k < 6; k++)
				queue_sample(edge_a[k], edge_b[k], edge_c[k]);
		end

		for (phase = 0; phase < 7; phase++) begin
			case (phase)
				0: begin lo = 8'hDF; hi = 8'h07; end
				1: begin lo = 8'hFF; hi = 8'hFF; end
				2: begin lo = 8'h00; hi = 8'h00; end
				default: begin lo = 8'($urandom); hi = 8'($urandom); end
			endcase
			queue_otp(lo, hi);
			if (phase == 3)
				queue_marker(OP_STEADY, 1'b1);
			for (n = 0; n < 100; n++) begin
				if ((phase == 1 && n == 10) || (phase == 3 && n == 20) || (phase == 5 && n == 40))
					queue_marker(OP_STALL, 1'b0);
				if (phase == 4 && n == 50)
					queue_marker(OP_DRAIN, 1'b0);
				queue_sample(pick_count(), pick_count(), pick_count());
			end
			if (phase == 3)
				queue_marker(OP_STEADY, 1'b0);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_ops.size() != 0 || in_valid || cfg_valid || expected_fields.size() != 0)
			@(posedge clk);
		repeat (SETTLE * 2) @(posedge clk);

		$display("Run covered %0d calibrated samples, %0d OTP writes and %0d long output stalls.",
			samples_checked, cfg_writes, stall_served);
		if (mismatches == 0 && stray_results == 0 && expected_fields.size() == 0) begin
			$display("PASS magnetometer_sample_calibrate_unit");
		end else begin
			$display("%0d mismatches, %0d unexpected results", mismatches, stray_results);
			$display("FAIL magnetometer_sample_calibrate_unit");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/msc_pkg.sv
hw/rtl/msc_gain.sv
hw/rtl/magnetometer_sample_calibrate_unit.sv
hw/rtl/msc_chk.sv
bench/magnetometer_sample_calibrate_unit_test.sv
